// ===== src/dcs_pkg.sv =====
// Shared types and constants for the descriptor coalescer.
// No dependencies; every other source file imports this package.
package dcs_pkg;

   localparam int FILE_W = 16;
   localparam int BUF_W = 64;
   localparam int LEN_W = 32;
   localparam int OFF_W = 63;
   localparam int BS_W = 32;
   localparam int CNT_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BS_W-1:0] DEFAULT_BLOCK = 32'd4194304;
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(OFF_W - 1);

   // register index decoded from paddr[2]
   localparam logic REG_FALLBACK = 1'b0;

   typedef struct packed {
      logic [FILE_W-1:0] file_id;
      logic [BUF_W-1:0]  buf_addr;
      logic [LEN_W-1:0]  length;
      logic [OFF_W-1:0]  file_offset;
      logic [OFF_W-1:0]  block_end;
      logic              last;
   } dcs_entry_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_DIV,
      FS_PUSH
   } dcs_front_state_type;

endpackage

// ===== src/dcs_if.sv =====
// Handshake channels for descriptor words and merged result words.
// Depends on dcs_pkg for field widths.
interface dcs_req_if;
   import dcs_pkg::*;
   logic              valid;
   logic              ready;
   logic [FILE_W-1:0] file_id;
   logic [BUF_W-1:0]  buf_addr;
   logic [LEN_W-1:0]  length;
   logic [OFF_W-1:0]  file_offset;
   logic [BS_W-1:0]   block_size;
   logic              last;
   modport source (output valid, file_id, buf_addr, length, file_offset, block_size, last,
                   input ready);
   modport sink (input valid, file_id, buf_addr, length, file_offset, block_size, last,
                 output ready);
endinterface

interface dcs_rsp_if;
   import dcs_pkg::*;
   logic              valid;
   logic              ready;
   logic [FILE_W-1:0] out_file_id;
   logic [BUF_W-1:0]  out_buf_addr;
   logic [LEN_W-1:0]  out_length;
   logic [OFF_W-1:0]  out_file_offset;
   logic              out_last;
   modport source (output valid, out_file_id, out_buf_addr, out_length, out_file_offset,
                   out_last, input ready);
   modport sink (input valid, out_file_id, out_buf_addr, out_length, out_file_offset,
                 out_last, output ready);
endinterface

// ===== src/dcs_front.sv =====
// Front end: accept a descriptor word and find the end of its filesystem block.
// Depends on dcs_pkg and dcs_req_if; feeds dcs_fifo.
module dcs_front (
   input  logic                      clock,
   input  logic                      reset,
   dcs_req_if.sink                   req,
   input  logic [dcs_pkg::BS_W-1:0]  fallback,
   input  logic                      fifo_full,
   output logic                      push,
   output dcs_pkg::dcs_entry_type    push_entry
);
   import dcs_pkg::*;

   dcs_front_state_type state_ff, state_in;
   logic [FILE_W-1:0] file_ff;
   logic [BUF_W-1:0]  buf_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [OFF_W-1:0]  off_ff;
   logic              last_ff;
   logic [BS_W-1:0]   blk_ff, blk_in;
   logic [BS_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [BS_W:0]     trial;
   logic [BUF_W-1:0]  end_raw;
   logic              accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: if (req.valid) state_in = FS_DIV;
         FS_DIV:  if (cnt_ff == '0) state_in = FS_PUSH;
         FS_PUSH: if (!fifo_full) state_in = FS_IDLE;
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      push = 1'b0;
      unique case (state_ff)
         FS_IDLE: req.ready = 1'b1;
         FS_DIV:  ;
         FS_PUSH: push = !fifo_full;
         default: ;
      endcase
   end

   assign accept = req.valid && req.ready;

   // zero block size takes the fallback, a zero fallback takes the default
   always_comb begin
      if (req.block_size != '0) begin
         blk_in = req.block_size;
      end else if (fallback != '0) begin
         blk_in = fallback;
      end else begin
         blk_in = DEFAULT_BLOCK;
      end
   end

   // one restoring remainder step per cycle, offset MSB first
   always_comb begin
      trial = {rem_ff, off_ff[cnt_ff]};
      if (trial >= {1'b0, blk_ff}) begin
         rem_in = BS_W'(trial - {1'b0, blk_ff});
      end else begin
         rem_in = trial[BS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         file_ff <= req.file_id;
         buf_ff <= req.buf_addr;
         len_ff <= req.length;
         off_ff <= req.file_offset;
         last_ff <= req.last;
         blk_ff <= blk_in;
         rem_ff <= '0;
         cnt_ff <= LAST_BIT;
      end else if (state_ff == FS_DIV) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // block end = offset - remainder + block size, saturated to 63 bits
   assign end_raw = {1'b0, off_ff} - BUF_W'(rem_ff) + BUF_W'(blk_ff);

   always_comb begin
      push_entry.file_id = file_ff;
      push_entry.buf_addr = buf_ff;
      push_entry.length = len_ff;
      push_entry.file_offset = off_ff;
      push_entry.block_end = end_raw[BUF_W-1] ? {OFF_W{1'b1}} : end_raw[OFF_W-1:0];
      push_entry.last = last_ff;
   end

endmodule

// ===== src/dcs_fifo.sv =====
// Two-entry queue of classified descriptors between front and back end.
// Depends on dcs_pkg.
module dcs_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dcs_pkg::dcs_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output dcs_pkg::dcs_entry_type pop_entry
);
   import dcs_pkg::*;

   dcs_entry_type slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   assign full = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_entry = slot_ff[rd_ff];

endmodule

// ===== src/dcs_back.sv =====
// Back end: merge queued descriptors into the pending one and emit result words.
// Depends on dcs_pkg and dcs_rsp_if; fed by dcs_fifo.
module dcs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   not_empty,
   input  dcs_pkg::dcs_entry_type entry,
   output logic                   pop,
   dcs_rsp_if.source              rsp
);
   import dcs_pkg::*;

   logic              pv_ff, pv_in;
   logic [FILE_W-1:0] pfile_ff, pfile_in;
   logic [BUF_W-1:0]  pbuf_ff, pbuf_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [OFF_W-1:0]  poff_ff, poff_in;
   logic [OFF_W-1:0]  pend_ff, pend_in;
   logic              flush2_ff, flush2_in;
   logic              ovalid_ff, ovalid_in;
   logic [FILE_W-1:0] ofile_ff, ofile_in;
   logic [BUF_W-1:0]  obuf_ff, obuf_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;
   logic [OFF_W-1:0]  ooff_ff, ooff_in;
   logic              olast_ff, olast_in;
   logic              out_free, merged;
   logic [BUF_W-1:0]  tail_off;
   logic [BUF_W:0]    merged_end;
   logic [LEN_W:0]    len_sum;
   logic [LEN_W-1:0]  len_sat;

   assign out_free = !ovalid_ff || rsp.ready;
   assign pop = not_empty && !flush2_ff && out_free;

   assign tail_off = {1'b0, poff_ff} + BUF_W'(plen_ff);
   assign merged_end = {1'b0, tail_off} + (BUF_W+1)'(entry.length);
   assign len_sum = {1'b0, plen_ff} + {1'b0, entry.length};
   assign len_sat = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
   assign merged = pv_ff && (pfile_ff == entry.file_id)
                   && (pbuf_ff + BUF_W'(plen_ff) == entry.buf_addr)
                   && (tail_off == {1'b0, entry.file_offset})
                   && (merged_end <= {2'b0, pend_ff});

   always_comb begin
      pv_in = pv_ff;
      pfile_in = pfile_ff;
      pbuf_in = pbuf_ff;
      plen_in = plen_ff;
      poff_in = poff_ff;
      pend_in = pend_ff;
      flush2_in = flush2_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      ofile_in = ofile_ff;
      obuf_in = obuf_ff;
      olen_in = olen_ff;
      ooff_in = ooff_ff;
      olast_in = olast_ff;
      if (flush2_ff && out_free) begin
         // second word of a split flush: the reloaded descriptor, marked last
         ovalid_in = 1'b1;
         ofile_in = pfile_ff;
         obuf_in = pbuf_ff;
         olen_in = plen_ff;
         ooff_in = poff_ff;
         olast_in = 1'b1;
         flush2_in = 1'b0;
      end else if (pop) begin
         if (merged) begin
            plen_in = len_sat;
            if (entry.last) begin
               ovalid_in = 1'b1;
               ofile_in = pfile_ff;
               obuf_in = pbuf_ff;
               olen_in = len_sat;
               ooff_in = poff_ff;
               olast_in = 1'b1;
            end
         end else begin
            pfile_in = entry.file_id;
            pbuf_in = entry.buf_addr;
            plen_in = entry.length;
            poff_in = entry.file_offset;
            pend_in = entry.block_end;
            if (pv_ff) begin
               // emit the old pending word; a last entry then follows next
               ovalid_in = 1'b1;
               ofile_in = pfile_ff;
               obuf_in = pbuf_ff;
               olen_in = plen_ff;
               ooff_in = poff_ff;
               olast_in = 1'b0;
               flush2_in = entry.last;
            end else if (entry.last) begin
               ovalid_in = 1'b1;
               ofile_in = entry.file_id;
               obuf_in = entry.buf_addr;
               olen_in = entry.length;
               ooff_in = entry.file_offset;
               olast_in = 1'b1;
            end
         end
         pv_in = !entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         pfile_ff <= '0;
         pbuf_ff <= '0;
         plen_ff <= '0;
         poff_ff <= '0;
         pend_ff <= '0;
         flush2_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         pfile_ff <= pfile_in;
         pbuf_ff <= pbuf_in;
         plen_ff <= plen_in;
         poff_ff <= poff_in;
         pend_ff <= pend_in;
         flush2_ff <= flush2_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ofile_ff <= ofile_in;
      obuf_ff <= obuf_in;
      olen_ff <= olen_in;
      ooff_ff <= ooff_in;
      olast_ff <= olast_in;
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.out_file_id = ofile_ff;
   assign rsp.out_buf_addr = obuf_ff;
   assign rsp.out_length = olen_ff;
   assign rsp.out_file_offset = ooff_ff;
   assign rsp.out_last = olast_ff;

   a_flush2_no_pending: assert property (@(posedge clock) disable iff (reset)
      flush2_ff |-> !pv_ff)
      else $error("split flush while a descriptor is still pending");
   a_flush2_first_word: assert property (@(posedge clock) disable iff (reset)
      $rose(flush2_ff) |-> (ovalid_ff && !olast_ff))
      else $error("split flush without its leading word");
   a_no_pop_in_flush: assert property (@(posedge clock) disable iff (reset)
      pop |-> !flush2_ff)
      else $error("queue popped during split flush");

endmodule

// ===== src/io_descriptor_coalescer.sv =====
// Descriptor coalescer top level: APB register, front end, queue, back end.
// Each word passes through the front end in order: accept, 63 remainder steps
// of the serial block-end divider, then entry into the queue; a new word is taken
// once the previous one is queued. The back end drives result words from an output register.
// Reset (synchronous, active high) clears the pending descriptor, the queue and
// the result register and sets fallback_block_size to 4194304.
module io_descriptor_coalescer (
   input  logic                               clock,
   input  logic                               reset,
   dcs_req_if.sink                            req,
   dcs_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dcs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dcs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dcs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import dcs_pkg::*;

   logic [BS_W-1:0] fallback_ff;
   logic            reg_sel;
   logic            csr_write;
   logic            push, full, pop, not_empty;
   dcs_entry_type   push_entry, pop_entry;

   // Register file: one word, decoded on paddr[2]; higher words read zero.
   assign pready = 1'b1;
   assign reg_sel = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff <= DEFAULT_BLOCK;
      end else if (csr_write && reg_sel == REG_FALLBACK) begin
         fallback_ff <= pwdata;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FALLBACK: prdata = fallback_ff;
         default:      prdata = '0;
      endcase
   end

   // Front end: classify each word and compute its block end.
   dcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .fallback   (fallback_ff),
      .fifo_full  (full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue: decouple the divider from the merge stage.
   dcs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   // Back end: merge into the pending descriptor and drive result words.
   dcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .entry     (pop_entry),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for io_descriptor_coalescer: random descriptor chains,
// APB writes of the fallback block size and a scoreboard that predicts merged words.
// Depends on dcs_pkg, dcs_if and the io_descriptor_coalescer RTL.
`timescale 1ns / 100ps

module tb_top;
   import dcs_pkg::*;

   localparam int HOLD_CYCLES  = 6000;    // long receiver hold-off
   localparam int DRAIN_CYCLES = 100;     // margin to empty the front end and the output reg
   localparam int IDLE_LIMIT   = 20000;   // cycles with no handshake before giving up
   localparam int RAND_WORDS   = 1800;
   localparam logic [OFF_W-1:0] OFF_MAX = '1;

   typedef struct packed {
      logic [FILE_W-1:0] file_id;
      logic [BUF_W-1:0]  buf_addr;
      logic [LEN_W-1:0]  length;
      logic [OFF_W-1:0]  file_offset;
      logic [BS_W-1:0]   block_size;
      logic              last;
   } desc_word_type;

   typedef struct packed {
      logic [FILE_W-1:0] file_id;
      logic [BUF_W-1:0]  buf_addr;
      logic [LEN_W-1:0]  length;
      logic [OFF_W-1:0]  file_offset;
      logic              last;
   } merged_word_type;

   // Tracks the pending merged descriptor and the merged words still owed by the block.
   class merge_scoreboard;
      logic [BS_W-1:0]   fallback_size;
      bit                pend_valid;
      logic [FILE_W-1:0] pend_file;
      logic [BUF_W-1:0]  pend_buf;
      logic [LEN_W-1:0]  pend_len;
      logic [OFF_W-1:0]  pend_off;
      logic [OFF_W-1:0]  pend_block_end;
      merged_word_type   owed_words[$];
      int                fail_count;

      function new();
         fallback_size = DEFAULT_BLOCK;
         pend_valid = 0;
         fail_count = 0;
      endfunction

      function void push_pending(bit last_flag);
         merged_word_type w;
         w.file_id = pend_file;
         w.buf_addr = pend_buf;
         w.length = pend_len;
         w.file_offset = pend_off;
         w.last = last_flag;
         owed_words.insert(owed_words.size(), w);
      endfunction

      // Compute the merged words caused by one accepted descriptor word.
      function void note_word(desc_word_type d);
         logic [63:0] blk, blk_end, tail_off, merged_end;
         logic [32:0] sum;
         bit merged;
         merged = 0;
         if (pend_valid) begin
            tail_off = {1'b0, pend_off} + 64'(pend_len);
            merged_end = tail_off + 64'(d.length);
            if (pend_file == d.file_id && pend_buf + 64'(pend_len) == d.buf_addr &&
                tail_off == {1'b0, d.file_offset} && merged_end <= {1'b0, pend_block_end}) begin
               sum = 33'(pend_len) + 33'(d.length);
               pend_len = sum[32] ? '1 : sum[31:0];
               merged = 1;
            end
         end
         if (!merged) begin
            if (pend_valid) push_pending(1'b0);
            // block size zero falls back to the register, and a zero register to the default
            blk = (d.block_size != 0) ? 64'(d.block_size) :
                  (fallback_size != 0) ? 64'(fallback_size) : 64'(DEFAULT_BLOCK);
            blk_end = ({1'b0, d.file_offset} / blk + 64'd1) * blk;
            if (blk_end > {1'b0, OFF_MAX}) blk_end = {1'b0, OFF_MAX};
            pend_valid = 1;
            pend_file = d.file_id;
            pend_buf = d.buf_addr;
            pend_len = d.length;
            pend_off = d.file_offset;
            pend_block_end = blk_end[OFF_W-1:0];
         end
         if (d.last) begin
            push_pending(1'b1);
            pend_valid = 0;
         end
      endfunction

      function void check_word(merged_word_type got);
         merged_word_type want;
         if (owed_words.size() == 0) begin
            $display("%0t: unexpected merged word file %h buf %h len %h off %h last %b",
                     $time, got.file_id, got.buf_addr, got.length, got.file_offset, got.last);
            fail_count++;
            return;
         end
         want = owed_words.pop_front();
         if (want != got) begin
            $display("%0t: mismatch expected file %h buf %h len %h off %h last %b",
                     $time, want.file_id, want.buf_addr, want.length, want.file_offset,
                     want.last);
            $display("%0t:          actual   file %h buf %h len %h off %h last %b",
                     $time, got.file_id, got.buf_addr, got.length, got.file_offset, got.last);
            fail_count++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   dcs_req_if req_bus();
   dcs_rsp_if rsp_bus();

   merge_scoreboard board = new();
   bit hold_request = 0;
   int idle_cycles = 0;

   io_descriptor_coalescer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus.sink),
      .rsp     (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // Gap length: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 98) return $urandom_range(5, 30);
      return $urandom_range(100, 400);
   endfunction

   function automatic logic [OFF_W-1:0] rand_off();
      return OFF_W'({$urandom, $urandom});
   endfunction

   // Offer one word, hold it until accepted, then idle for a random gap.
   task automatic send_word(desc_word_type d);
      int gap;
      req_bus.valid <= 1;
      req_bus.file_id <= d.file_id;
      req_bus.buf_addr <= d.buf_addr;
      req_bus.length <= d.length;
      req_bus.file_offset <= d.file_offset;
      req_bus.block_size <= d.block_size;
      req_bus.last <= d.last;
      do @(posedge clock); while (!req_bus.ready);
      board.note_word(d);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed word is out and the front end is empty.
   task automatic drain();
      req_bus.valid <= 0;
      @(posedge clock);
      while (board.owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_fallback(logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {REG_FALLBACK, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      board.fallback_size = value;
   endtask

   function automatic desc_word_type make_word(logic [15:0] f, logic [63:0] b, logic [31:0] n,
                                               logic [62:0] o, logic [31:0] bs, logic l);
      desc_word_type d;
      d.file_id = f;
      d.buf_addr = b;
      d.length = n;
      d.file_offset = o;
      d.block_size = bs;
      d.last = l;
      return d;
   endfunction

   function automatic logic [31:0] pick_block_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 0;
      if (r < 8) return 32'd1 << $urandom_range(6, 16);
      if (r < 9) return $urandom_range(1, 5000);
      return 32'h8000_0000;
   endfunction

   // A chain of contiguous descriptors with random content; a few links broken.
   task automatic send_chain(ref int sent);
      desc_word_type d;
      int links, k;
      logic [31:0] bs;
      links = $urandom_range(1, 12);
      bs = pick_block_size();
      d = make_word(16'($urandom_range(0, 3)), {$urandom, $urandom}, 32'd0, 63'd0, bs, 1'b0);
      d.file_offset = ($urandom_range(0, 3) == 0) ? OFF_MAX - $urandom_range(0, 70000)
                                                 : 63'($urandom);
      for (k = 0; k < links; k++) begin
         d.length = ($urandom_range(0, 19) == 0) ? 32'($urandom) : $urandom_range(0, 3000);
         d.last = (k == links - 1) && ($urandom_range(0, 9) < 7);
         send_word(d);
         sent++;
         d.buf_addr += 64'(d.length);
         d.file_offset += 63'(d.length);
         case ($urandom_range(0, 19))
            0: d.file_id ^= 16'h1;
            1: d.buf_addr += 64'd8;
            2: d.file_offset += 63'd1;
            default: ;
         endcase
      end
   endtask

   task automatic send_noise(ref int sent);
      desc_word_type d;
      d = make_word(16'($urandom), {$urandom, $urandom}, $urandom, rand_off(), $urandom,
                    1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) d.block_size = 0;
      send_word(d);
      sent++;
   endtask

   // Receiver: random ready with short and long stalls, plus one long hold on request.
   initial begin
      bit hold_taken;
      hold_taken = 0;
      rsp_bus.ready <= 0;
      forever begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1;
            rsp_bus.ready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1;
            @(posedge clock);
         end else begin
            int gap;
            gap = pick_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 0;
               repeat (gap) @(posedge clock);
            end
            rsp_bus.ready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Check every merged word as it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         merged_word_type got;
         got.file_id = rsp_bus.out_file_id;
         got.buf_addr = rsp_bus.out_buf_addr;
         got.length = rsp_bus.out_length;
         got.file_offset = rsp_bus.out_file_offset;
         got.last = rsp_bus.out_last;
         board.check_word(got);
      end
   end

   // Watchdog: abort when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("io_descriptor_coalescer regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] settings[6];
      int sent, phase, quota;
      req_bus.valid <= 0;
      req_bus.file_id <= '0;
      req_bus.buf_addr <= '0;
      req_bus.length <= '0;
      req_bus.file_offset <= '0;
      req_bus.block_size <= '0;
      req_bus.last <= 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: zero lengths, address wrap, block boundary, saturated block end, extremes.
      send_word(make_word(16'h0, 64'h0, 32'd0, 63'd0, 32'd0, 1'b0));
      send_word(make_word(16'h0, 64'h0, 32'd100, 63'd0, 32'd0, 1'b0));
      send_word(make_word(16'h0, 64'd100, 32'd50, 63'd100, 32'd0, 1'b1));
      send_word(make_word(16'hffff, 64'hffff_ffff_ffff_ff00, 32'd256, 63'd0, 32'd4096, 1'b0));
      send_word(make_word(16'hffff, 64'h0, 32'd16, 63'd256, 32'd4096, 1'b1));
      send_word(make_word(16'h5, 64'h1000, 32'd96, 63'd4000, 32'd4096, 1'b0));
      send_word(make_word(16'h5, 64'h1060, 32'd1, 63'd4096, 32'd4096, 1'b1));
      send_word(make_word(16'h7, 64'h2000, 32'd15, OFF_MAX - 63'd15, 32'h8000_0000, 1'b0));
      send_word(make_word(16'h7, 64'h200f, 32'd0, OFF_MAX, 32'h8000_0000, 1'b1));
      send_word(make_word(16'hffff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, OFF_MAX,
                          32'hffff_ffff, 1'b0));
      send_word(make_word(16'h1234, 64'h0, 32'hffff_ffff, 63'd0, 32'd1, 1'b1));
      send_word(make_word(16'h9, 64'h40, 32'd64, 63'd64, 32'd64, 1'b0));
      send_word(make_word(16'h9, 64'h80, 32'd64, 63'd128, 32'd64, 1'b1));
      drain();

      // Zero register falls back to the default; then the extremes and a few others.
      settings[0] = 32'd0;
      settings[1] = 32'd1;
      settings[2] = 32'h8000_0000;
      settings[3] = $urandom_range(1, 100000);
      settings[4] = 32'd4096;
      settings[5] = DEFAULT_BLOCK;
      sent = 0;
      for (phase = 0; phase < 6; phase++) begin
         write_fallback(settings[phase]);
         send_word(make_word(16'h3, 64'h0, 32'd10, 63'd0, 32'd0, 1'b0));
         send_word(make_word(16'h3, 64'd10, 32'd10, 63'd10, 32'd0, 1'b1));
         sent += 2;
         if (phase == 2) hold_request = 1;   // let the block fill and stall its input
         quota = (RAND_WORDS * (phase + 1)) / 6;
         while (sent < quota) begin
            if ($urandom_range(0, 4) == 0) send_noise(sent);
            else send_chain(sent);
         end
         // flush whatever is pending so the last word always comes out
         send_word(make_word(16'h0, 64'h0, 32'd0, 63'd0, 32'd0, 1'b1));
         drain();
      end

      if (board.fail_count == 0) begin
         $display("io_descriptor_coalescer regression: pass");
      end else begin
         $display("io_descriptor_coalescer regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dcs_pkg.sv
src/dcs_if.sv
src/dcs_front.sv
src/dcs_fifo.sv
src/dcs_back.sv
src/io_descriptor_coalescer.sv
dv/tb_top.sv
